// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the record stack RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define VRBS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define VRBS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/vrbs_pkg.sv =====
// Shared constants, codes and control structs of the record stack.
`default_nettype none

package vrbs_pkg;

  // Default sizes of the store and the length header
  localparam int STORE_BYTES_DEF  = 1024;
  localparam int HEADER_BYTES_DEF = 2;

  // Longest record; requested lengths saturate here
  localparam int MAX_RECORD = 64;

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int LEN_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic acc_push;   // push beat taken
    logic acc_rd;     // pop or peek taken on a non-empty stack
    logic acc_empty;  // pop or peek taken on an empty stack
    logic acc_clear;  // clear taken
    logic hdr_wr;     // write one header byte
    logic pdata_wr;   // write the held first record byte
    logic hdr_rd;     // read one header byte
    logic hdr_end;    // last header byte arrives, set up the stream
    logic str_rd;     // read one record byte
    logic out_data;   // load a record byte into the output register
    logic out_zero;   // load an empty ok result
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic top_empty;   // stack holds no record
    logic room;        // room for the offered record plus header
    logic push_active; // a push is under way
    logic hdr_last;    // header byte counter at its last byte
    logic cnt_zero;    // nothing to return (valid with hdr_end)
    logic rd_last;     // byte being read is the final one
    logic out_free;    // output register free for the next cycle
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/vrbs_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none

module vrbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vrbs_ctrl.sv =====
// Controller state machine of the record stack.
`default_nettype none

module vrbs_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  input  wire logic [vrbs_pkg::FUNC_W-1:0] in_func,
  input  wire vrbs_pkg::dp_stat_t          stat,
  output logic                             in_tready,
  output vrbs_pkg::ctl_cmd_t               cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_HDR  = 8'b0000_0010,
    S_PDAT = 8'b0000_0100,
    S_HRD  = 8'b0000_1000,
    S_HEND = 8'b0001_0000,
    S_ZERO = 8'b0010_0000,
    S_SRD  = 8'b0100_0000,
    S_SLD  = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   acc;

  // Take a beat only when idle and the output register can take its result
  assign in_tready = (state_r == S_IDLE) && stat.out_free;
  assign acc       = in_tvalid && in_tready;

  // Decode state and beat into datapath commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_func)
            vrbs_pkg::FUNC_PUSH: begin
              cmd.acc_push = 1'b1;
              if (!stat.push_active && stat.room) begin
                state_nxt = S_HDR;
              end
            end
            vrbs_pkg::FUNC_POP, vrbs_pkg::FUNC_PEEK: begin
              if (stat.top_empty) begin
                cmd.acc_empty = 1'b1;
              end else begin
                cmd.acc_rd = 1'b1;
                state_nxt  = S_HRD;
              end
            end
            vrbs_pkg::FUNC_CLEAR: begin
              cmd.acc_clear = 1'b1;
            end
            default: begin
              cmd.acc_clear = 1'b1;
            end
          endcase
        end
      end
      S_HDR: begin
        cmd.hdr_wr = 1'b1;
        if (stat.hdr_last) begin
          state_nxt = S_PDAT;
        end
      end
      S_PDAT: begin
        cmd.pdata_wr = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_HRD: begin
        cmd.hdr_rd = 1'b1;
        if (stat.hdr_last) begin
          state_nxt = S_HEND;
        end
      end
      S_HEND: begin
        cmd.hdr_end = 1'b1;
        state_nxt   = stat.cnt_zero ? S_ZERO : S_SRD;
      end
      S_ZERO: begin
        if (stat.out_free) begin
          cmd.out_zero = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SRD: begin
        // Read only when the output register is free by the next cycle
        if (stat.out_free) begin
          cmd.str_rd = 1'b1;
          state_nxt  = S_SLD;
        end
      end
      S_SLD: begin
        cmd.out_data = 1'b1;
        state_nxt    = stat.rd_last ? S_IDLE : S_SRD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vrbs_dp.sv =====
// Datapath of the record stack: pointers, byte store and output register.
`default_nettype none

module vrbs_dp #(
  parameter int STORE_BYTES  = vrbs_pkg::STORE_BYTES_DEF,
  parameter int HEADER_BYTES = vrbs_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [vrbs_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic [vrbs_pkg::FUNC_W-1:0]       in_tuser,
  input  wire logic                              in_tlast,
  input  wire vrbs_pkg::ctl_cmd_t                cmd,
  output vrbs_pkg::dp_stat_t                     stat,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [vrbs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                   out_tuser,
  output logic                                   out_tlast
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int TW = $clog2(STORE_BYTES + 1);
  localparam int CW = (TW > 8) ? TW : 8;
  localparam int KW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int LW = vrbs_pkg::LEN_W;
  localparam int BW = vrbs_pkg::BYTE_W;
  localparam int SW = vrbs_pkg::STATUS_W;

  localparam logic [TW-1:0]   TOP_EMPTY = TW'(STORE_BYTES);
  localparam logic [LW-1:0]   LEN_MAX   = LW'(vrbs_pkg::MAX_RECORD);
  localparam logic [KW-1:0]   K_LAST    = KW'(HEADER_BYTES - 1);

  // Input fields
  logic [LW-1:0] rec_len;
  logic [BW-1:0] data_in;
  logic [LW-1:0] req_sat;
  logic          acc;

  // Registers
  logic [TW-1:0] top_r,      top_nxt;
  logic [LW-1:0] req_r,      req_nxt;
  logic          pop_r,      pop_nxt;
  logic          active_r,   active_nxt;
  logic          rej_r,      rej_nxt;
  logic [LW-1:0] remain_r,   remain_nxt;
  logic [TW-1:0] wr_ptr_r,   wr_ptr_nxt;
  logic [BW-1:0] hold_r,     hold_nxt;
  logic [KW-1:0] k_r,        k_nxt;
  logic          hpend_r,    hpend_nxt;
  logic [KW-1:0] hidx_r,     hidx_nxt;
  logic [BW-1:0] lo_r,       lo_nxt;
  logic          over_r,     over_nxt;
  logic [LW-1:0] cnt_r,      cnt_nxt;
  logic [TW-1:0] rd_ptr_r,   rd_ptr_nxt;
  logic          last_r,     last_nxt;
  logic          ov_r,       ov_nxt;
  logic [SW-1:0] ost_r,      ost_nxt;
  logic [BW-1:0] odata_r,    odata_nxt;
  logic          odv_r,      odv_nxt;
  logic          olast_r,    olast_nxt;
  logic          oempty_r,   oempty_nxt;
  logic          ofull_r,    ofull_nxt;

  // Arithmetic and memory port
  logic [CW-1:0] need_in;
  logic [CW-1:0] need_cur;
  logic [LW-1:0] req_cur;
  logic [TW-1:0] hdr_addr;
  logic [BW-1:0] lo_c;
  logic          over_c;
  logic [LW-1:0] stored;
  logic [LW-1:0] cnt_c;
  logic [CW:0]   pop_top;
  logic          data_wr;
  logic          load;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_addr;
  logic [BW-1:0] ram_wdata;
  logic [BW-1:0] ram_rdata;

  assign rec_len = in_tdata[LW-1:0];
  assign data_in = in_tdata[LW+BW-1:LW];
  assign req_sat = (rec_len > LEN_MAX) ? LEN_MAX : rec_len;
  assign acc     = cmd.acc_push || cmd.acc_rd || cmd.acc_empty || cmd.acc_clear;

  assign need_in  = CW'(req_sat) + CW'(HEADER_BYTES);
  assign hdr_addr = top_r + TW'(k_r);

  // Merge the arriving header byte into the stored length, clamped
  assign lo_c   = (hidx_r == '0) ? ram_rdata : lo_r;
  assign over_c = over_r || ((hidx_r != '0) && (ram_rdata != '0));
  assign stored = (over_c || (lo_c > BW'(vrbs_pkg::MAX_RECORD))) ? LEN_MAX : lo_c[LW-1:0];
  assign cnt_c  = (stored < req_r) ? stored : req_r;
  assign pop_top = (CW+1)'(top_r) + (CW+1)'(HEADER_BYTES) + (CW+1)'(stored);

  // Status toward the controller
  always_comb begin
    stat.top_empty   = (top_r == TOP_EMPTY);
    stat.room        = (CW'(top_r) >= need_in);
    stat.push_active = active_r;
    stat.hdr_last    = (k_r == K_LAST);
    stat.cnt_zero    = (cnt_c == '0);
    stat.rd_last     = last_r;
    stat.out_free    = !ov_r || out_tready;
  end

  // Select the single memory access of this cycle
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    data_wr   = 1'b0;
    priority if (cmd.hdr_wr) begin
      ram_we    = 1'b1;
      ram_addr  = hdr_addr[AW-1:0];
      ram_wdata = (k_r == '0) ? {1'b0, req_r} : '0;
    end else if (cmd.pdata_wr && (remain_r != '0)) begin
      ram_we    = 1'b1;
      ram_addr  = wr_ptr_r[AW-1:0];
      ram_wdata = hold_r;
      data_wr   = 1'b1;
    end else if (cmd.acc_push && active_r && !rej_r && (remain_r != '0)) begin
      ram_we    = 1'b1;
      ram_addr  = wr_ptr_r[AW-1:0];
      ram_wdata = data_in;
      data_wr   = 1'b1;
    end else if (cmd.hdr_rd) begin
      ram_re   = 1'b1;
      ram_addr = hdr_addr[AW-1:0];
    end else if (cmd.str_rd) begin
      ram_re   = 1'b1;
      ram_addr = rd_ptr_r[AW-1:0];
    end else begin
      ram_re = 1'b0;
    end
  end

  // Next-state logic of pointers, push tracking and record streaming
  always_comb begin
    top_nxt    = top_r;
    req_nxt    = req_r;
    pop_nxt    = pop_r;
    active_nxt = active_r;
    rej_nxt    = rej_r;
    remain_nxt = remain_r;
    wr_ptr_nxt = wr_ptr_r;
    hold_nxt   = hold_r;
    k_nxt      = k_r;
    hpend_nxt  = cmd.hdr_rd;
    hidx_nxt   = k_r;
    lo_nxt     = lo_r;
    over_nxt   = over_r;
    cnt_nxt    = cnt_r;
    rd_ptr_nxt = rd_ptr_r;
    last_nxt   = last_r;

    if (acc) begin
      req_nxt = req_sat;
      pop_nxt = (in_tuser == vrbs_pkg::FUNC_POP);
      k_nxt   = '0;
    end

    // Push beat: open a record on the first beat, track the end marker
    if (cmd.acc_push) begin
      if (!active_r) begin
        if (stat.room) begin
          rej_nxt    = 1'b0;
          top_nxt    = top_r - TW'(need_in);
          wr_ptr_nxt = top_nxt + TW'(HEADER_BYTES);
          remain_nxt = req_sat;
          hold_nxt   = data_in;
        end else begin
          rej_nxt = 1'b1;
        end
      end
      if (in_tlast) begin
        active_nxt = 1'b0;
        rej_nxt    = 1'b0;
      end else begin
        active_nxt = 1'b1;
      end
    end

    if (cmd.acc_rd || cmd.acc_empty || cmd.acc_clear) begin
      active_nxt = 1'b0;
      rej_nxt    = 1'b0;
    end
    if (cmd.acc_clear) begin
      top_nxt = TOP_EMPTY;
    end
    if (cmd.acc_rd) begin
      over_nxt = 1'b0;
    end

    if (data_wr) begin
      wr_ptr_nxt = wr_ptr_r + TW'(1);
      remain_nxt = remain_r - LW'(1);
    end

    if (cmd.hdr_wr || cmd.hdr_rd) begin
      k_nxt = k_r + KW'(1);
    end

    // Accumulate header bytes as they come back
    if (hpend_r) begin
      lo_nxt   = lo_c;
      over_nxt = over_c;
    end

    // Set up the stream and free the record on pop
    if (cmd.hdr_end) begin
      cnt_nxt    = cnt_c;
      rd_ptr_nxt = top_r + TW'(HEADER_BYTES);
      if (pop_r) begin
        top_nxt = (pop_top > (CW+1)'(STORE_BYTES)) ? TOP_EMPTY : pop_top[TW-1:0];
      end
    end

    if (cmd.str_rd) begin
      rd_ptr_nxt = rd_ptr_r + TW'(1);
      cnt_nxt    = cnt_r - LW'(1);
      last_nxt   = (cnt_r == LW'(1));
    end
  end

  // Output register: load a result, drop it once taken
  assign req_cur  = acc ? req_sat : req_r;
  assign need_cur = CW'(req_cur) + CW'(HEADER_BYTES);
  assign load     = cmd.acc_push || cmd.acc_empty || cmd.acc_clear ||
                    cmd.out_data || cmd.out_zero;

  always_comb begin
    ov_nxt     = ov_r && !out_tready;
    ost_nxt    = ost_r;
    odata_nxt  = odata_r;
    odv_nxt    = odv_r;
    olast_nxt  = olast_r;
    oempty_nxt = oempty_r;
    ofull_nxt  = ofull_r;
    if (load) begin
      ov_nxt     = 1'b1;
      ost_nxt    = vrbs_pkg::ST_OK;
      odata_nxt  = '0;
      odv_nxt    = 1'b0;
      olast_nxt  = 1'b1;
      oempty_nxt = (top_nxt == TOP_EMPTY);
      ofull_nxt  = (CW'(top_nxt) < need_cur);
      if (cmd.acc_push && (active_r ? rej_r : !stat.room)) begin
        ost_nxt = vrbs_pkg::ST_NOMEM;
      end
      if (cmd.acc_empty) begin
        ost_nxt = vrbs_pkg::ST_EMPTY;
      end
      if (cmd.out_data) begin
        odata_nxt = ram_rdata;
        odv_nxt   = 1'b1;
        olast_nxt = last_r;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r    <= TOP_EMPTY;
      active_r <= 1'b0;
      rej_r    <= 1'b0;
      k_r      <= '0;
      hpend_r  <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      top_r    <= top_nxt;
      active_r <= active_nxt;
      rej_r    <= rej_nxt;
      k_r      <= k_nxt;
      hpend_r  <= hpend_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    pop_r    <= pop_nxt;
    remain_r <= remain_nxt;
    wr_ptr_r <= wr_ptr_nxt;
    hold_r   <= hold_nxt;
    hidx_r   <= hidx_nxt;
    lo_r     <= lo_nxt;
    over_r   <= over_nxt;
    cnt_r    <= cnt_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    last_r   <= last_nxt;
    ost_r    <= ost_nxt;
    odata_r  <= odata_nxt;
    odv_r    <= odv_nxt;
    olast_r  <= olast_nxt;
    oempty_r <= oempty_nxt;
    ofull_r  <= ofull_nxt;
  end

  // Byte store
  vrbs_ram #(
    .WIDTH (BW),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'b0000, ofull_r, oempty_r, odata_r, ost_r};
  assign out_tuser  = odv_r;
  assign out_tlast  = olast_r;

endmodule

`default_nettype wire

// ===== rtl/core/variable_record_byte_stack.sv =====
// Stack of variable-length byte records in a downward-growing byte store.
// Each record sits as its data bytes above a little-endian length header of
// HEADER_BYTES bytes. A push streams a record in one beat per byte; its first
// beat checks for room for the length plus header, and a record without room
// is dropped with status no-memory on each of its beats. Pop and peek return
// min(stored length, requested length) bytes, and pop frees the whole record.
// Clear empties the stack. Every result also carries is_empty and
// full_for_len. A continuing push beat or a rejected first beat is handled
// in the idle state; an accepted first beat then steps through the header
// writes and the first-byte write on the single memory port. Pop and peek
// first step through the header reads, then read and load each returned
// byte in turn, the registered memory read feeding the one output register; a
// read with nothing to return loads an empty ok result after the header reads.
// A read of an empty stack and a clear are answered in the idle state. Output
// stalls add to these steps. The store needs no clearing pass after reset.
`default_nettype none
`include "assert_macros.svh"

module variable_record_byte_stack #(
  parameter int STORE_BYTES  = vrbs_pkg::STORE_BYTES_DEF,
  parameter int HEADER_BYTES = vrbs_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: rec_len[6:0], data_in[14:7], zero[15]
  input  wire logic [vrbs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: func[1:0]
  input  wire logic [vrbs_pkg::FUNC_W-1:0]      in_tuser,
  input  wire logic                             in_tlast,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // out_tdata: status[1:0], data_out[9:2], is_empty[10], full_for_len[11], zero[15:12]
  output logic      [vrbs_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: data_valid[0]
  output logic                                  out_tuser,
  output logic                                  out_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready
);

  vrbs_pkg::ctl_cmd_t cmd;
  vrbs_pkg::dp_stat_t stat;

  // Result fields and command set watched by the checks
  logic [vrbs_pkg::STATUS_W-1:0] out_status;
  logic                          out_ok;
  logic                          out_is_empty;
  logic                          byte_beat;
  logic                          empty_beat;
  logic [7:0]                    step_cmds;

  vrbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser),
    .stat      (stat),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  vrbs_dp #(
    .STORE_BYTES  (STORE_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign out_status   = out_tdata[1:0];
  assign out_ok       = (out_status == vrbs_pkg::ST_OK);
  assign out_is_empty = out_tdata[10];
  assign byte_beat    = out_tvalid && out_tuser;
  assign empty_beat   = out_tvalid && (out_status == vrbs_pkg::ST_EMPTY);
  assign step_cmds    = {cmd.hdr_wr, cmd.pdata_wr, cmd.hdr_rd, cmd.hdr_end,
                         cmd.str_rd, cmd.out_data, cmd.out_zero, in_tready};

  // A beat carrying a record byte is always an ok result
  `VRBS_ASSERT_IMPLY(a_data_ok, byte_beat, out_ok, "record byte with bad status")

  // An empty-stack result must report the stack as empty
  `VRBS_ASSERT_IMPLY(a_empty_flag, empty_beat, out_is_empty, "empty status without is_empty")

  // The sequencer issues at most one step command per cycle
  `VRBS_ASSERT_ALWAYS(a_cmd_excl, $onehot0(step_cmds), "overlapping datapath commands")

endmodule

`default_nettype wire
